// ----- hdl/tactile_contact_centroid_3x3_defines.svh -----
// Assertion macros used by the contact centroid top-level design file.
`ifndef TACTILE_CONTACT_CENTROID_3X3_DEFINES_SVH
`define TACTILE_CONTACT_CENTROID_3X3_DEFINES_SVH
`ifndef SYNTHESIS
`define TCC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tcc: assertion failed");
`define TCC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tcc: assertion failed");
`else
`define TCC_ASSERT_IMP(lbl, ante, cons)
`define TCC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- hdl/tcc_pkg.sv -----
// Types, constants and helpers for the tactile contact centroid block.
package tcc_pkg;
  localparam int GRID_ROWS_DEF = 16;
  localparam int GRID_COLS_DEF = 16;
  localparam int FORCE_W = 48;
  localparam int SUM_W   = 20;  // nine 16-bit pressures
  localparam int ACC_W   = 36;  // nine 16x16 signed products
  localparam int NUM_W   = 36;  // rounded dividend magnitude
  localparam int Q_W     = 17;  // quotient magnitude up to 32768

  typedef struct packed {
    logic [15:0] pressure;
    logic [15:0] cx;
    logic [15:0] cy;
    logic [15:0] cz;
    logic [15:0] nx;
    logic [15:0] ny;
    logic [15:0] nz;
    logic [15:0] w;
    logic [15:0] h;
  } texel_t;

  typedef struct packed {
    logic [3:0]         row;
    logic [3:0]         col;
    logic [5:0][15:0]   val;  // point x,y,z then dir x,y,z
    logic [FORCE_W-1:0] force_v;
  } res_t;

  // row mod 3 for rows below 64
  function automatic logic [1:0] mod3_f(input logic [5:0] r);
    logic [11:0] t;
    logic [5:0]  q;
    t = 12'(r) * 12'd43;
    q = 6'(t[11:7]);
    return 2'(r - q * 6'd3);
  endfunction
endpackage

// ----- hdl/tcc_if.sv -----
// Valid/ready channel interfaces for texel input and contact output.
interface tcc_in_if;
  logic               valid;
  logic               ready;
  logic        [15:0] pressure;
  logic signed [15:0] center_x;
  logic signed [15:0] center_y;
  logic signed [15:0] center_z;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;
  logic        [15:0] texel_width;
  logic        [15:0] texel_height;
  modport source (output valid, pressure, center_x, center_y, center_z,
                  normal_x, normal_y, normal_z, texel_width, texel_height,
                  input ready);
  modport sink (input valid, pressure, center_x, center_y, center_z,
                normal_x, normal_y, normal_z, texel_width, texel_height,
                output ready);
endinterface

interface tcc_out_if;
  logic               valid;
  logic               ready;
  logic        [3:0]  contact_row;
  logic        [3:0]  contact_col;
  logic signed [15:0] point_x;
  logic signed [15:0] point_y;
  logic signed [15:0] point_z;
  logic signed [15:0] dir_x;
  logic signed [15:0] dir_y;
  logic signed [15:0] dir_z;
  logic        [47:0] force_res;
  logic               last_of_run;
  modport source (output valid, contact_row, contact_col, point_x, point_y,
                  point_z, dir_x, dir_y, dir_z, force_res, last_of_run,
                  input ready);
  modport sink (input valid, contact_row, contact_col, point_x, point_y,
                point_z, dir_x, dir_y, dir_z, force_res, last_of_run,
                output ready);
endinterface

// ----- hdl/tcc_div.sv -----
// Restoring divider, one quotient bit per cycle.
module tcc_div import tcc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [SUM_W-1:0] den,
  output logic             busy,
  output logic             done,
  output logic [Q_W-1:0]   quo
);
  localparam int CNT_W = $clog2(Q_W + 1);

  logic [SUM_W-1:0] rem;
  logic [Q_W-1:0]   nq;
  logic [CNT_W-1:0] cnt;
  logic [SUM_W:0]   t;
  logic             ge;
  logic [SUM_W-1:0] rem_next;

  always_comb begin
    t        = {rem, nq[Q_W-1]};
    ge       = t >= {1'b0, den};
    rem_next = ge ? SUM_W'(t - {1'b0, den}) : SUM_W'(t);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      // pulse on the last quotient bit
      done <= !start && busy && (cnt == CNT_W'(1));
      if (start) begin
        // top bits are below den since the quotient fits Q_W bits
        rem  <= SUM_W'(num[NUM_W-1:Q_W]);
        nq   <= num[Q_W-1:0];
        cnt  <= CNT_W'(Q_W);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= rem_next;
        nq  <= {nq[Q_W-2:0], ge};
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign quo = nq;
endmodule

// ----- hdl/tactile_contact_centroid_3x3.sv -----
// Top level: weighted 3x3 contact centroid over a tactile pressure grid.
//
// Texels arrive on in_ch in raster order, one transfer per texel. Each texel
// is written to a three-row line memory, then every window that the texel
// completes (up to four) is evaluated: its nine or fewer texels are read one
// at a time and fed to a single shared multiplier (six products per texel),
// then two multiplies form the force, and, when the force exceeds min_force
// and the weight sum is nonzero, one shared restoring divider forms the six
// means one after another. in_ch.ready is high only while idle. Contacts
// leave on out_ch from an output register; each contact is held back until
// the next one or the end of its texel is known, so the last can carry
// last_of_run. A stalled receiver simply holds the block in place.
// cfg_we writes min_force; write only while idle.
// Reset (rst, synchronous) returns the grid position to row 0, column 0
// and clears min_force; line memory contents are left as they are.
`include "tactile_contact_centroid_3x3_defines.svh"
module tactile_contact_centroid_3x3 import tcc_pkg::*; #(
  parameter int GRID_ROWS = GRID_ROWS_DEF,
  parameter int GRID_COLS = GRID_COLS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [FORCE_W-1:0] cfg_wdata,
  tcc_in_if.sink             in_ch,
  tcc_out_if.source          out_ch
);
  localparam int ROW_W  = $clog2(GRID_ROWS);
  localparam int COL_W  = $clog2(GRID_COLS);
  localparam int DEPTH  = 3 * GRID_COLS;
  localparam int ADDR_W = $clog2(DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_WIN, S_RD, S_MAC, S_F1, S_F2, S_F3,
    S_DLOAD, S_DWAIT, S_PUSH, S_WAIT, S_END
  } state_t;

  state_t state;

  logic [FORCE_W-1:0] min_force;
  logic [ROW_W-1:0]   row_pos, cur_r, wi, rlo, rhi, rr;
  logic [COL_W-1:0]   col_pos, cur_c, wj, clo, chi, cc;
  logic [2:0]         win_idx;
  logic [2:0]         k;
  logic [2:0]         dk;

  texel_t             mem [DEPTH];
  texel_t             rd_q;
  texel_t             in_tex;
  logic [ADDR_W-1:0]  wr_addr, rd_addr;

  logic signed [49:0]      prod;
  logic signed [32:0]      mul_a;
  logic signed [16:0]      mul_b;
  logic signed [ACC_W-1:0] acc [6];
  logic [SUM_W-1:0]        sum;
  logic [15:0]             peak, sz_w, sz_h;
  logic [FORCE_W-1:0]      force_v;
  logic [5:0][15:0]        vals;
  logic                    dneg;

  logic                    div_start, div_busy, div_done;
  logic [NUM_W-1:0]        div_num;
  logic [Q_W-1:0]          div_q;
  logic signed [ACC_W-1:0] acc_sel;
  logic [ACC_W-1:0]        acc_mag;

  res_t pend, out_q;
  logic pend_v, out_valid, wait_end;

  // window choice for the current slot in the event order
  logic             win_ok;
  logic [ROW_W-1:0] win_i;
  logic [COL_W-1:0] win_j;

  assign in_ch.ready = (state == S_IDLE);
  assign in_tex = '{pressure: in_ch.pressure, cx: in_ch.center_x,
                    cy: in_ch.center_y, cz: in_ch.center_z,
                    nx: in_ch.normal_x, ny: in_ch.normal_y, nz: in_ch.normal_z,
                    w: in_ch.texel_width, h: in_ch.texel_height};

  assign wr_addr = ADDR_W'(ADDR_W'(mod3_f(6'(row_pos))) * ADDR_W'(GRID_COLS)
                           + ADDR_W'(col_pos));
  assign rd_addr = ADDR_W'(ADDR_W'(mod3_f(6'(rr))) * ADDR_W'(GRID_COLS)
                           + ADDR_W'(cc));

  // line memory: written on input transfer, read one texel per S_RD
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      mem[wr_addr] <= in_tex;
    end
    if (state == S_RD) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_comb begin
    win_ok = 1'b0;
    win_i  = cur_r;
    win_j  = cur_c;
    unique case (win_idx)
      3'd0: begin
        win_ok = (cur_r != '0) && (cur_c != '0);
        win_i  = cur_r - ROW_W'(1);
        win_j  = cur_c - COL_W'(1);
      end
      3'd1: begin
        win_ok = (cur_r != '0) && (cur_c == COL_W'(GRID_COLS - 1));
        win_i  = cur_r - ROW_W'(1);
      end
      3'd2: begin
        win_ok = (cur_r == ROW_W'(GRID_ROWS - 1)) && (cur_c != '0);
        win_j  = cur_c - COL_W'(1);
      end
      3'd3: begin
        win_ok = (cur_r == ROW_W'(GRID_ROWS - 1)) &&
                 (cur_c == COL_W'(GRID_COLS - 1));
      end
      default: win_ok = 1'b0;
    endcase
  end

  // shared multiplier operands
  always_comb begin
    mul_a = 33'(rd_q.pressure);
    mul_b = 17'(signed'(rd_q.cx));
    priority case (state)
      S_F1: begin
        mul_a = 33'(peak);
        mul_b = 17'(sz_w);
      end
      S_F2: begin
        mul_a = 33'(prod[31:0]);
        mul_b = 17'(sz_h);
      end
      default: begin
        unique case (k)
          3'd0:    mul_b = 17'(signed'(rd_q.cx));
          3'd1:    mul_b = 17'(signed'(rd_q.cy));
          3'd2:    mul_b = 17'(signed'(rd_q.cz));
          3'd3:    mul_b = 17'(signed'(rd_q.nx));
          3'd4:    mul_b = 17'(signed'(rd_q.ny));
          default: mul_b = 17'(signed'(rd_q.nz));
        endcase
      end
    endcase
  end

  always_comb begin
    acc_sel = acc[dk];
    acc_mag = (acc_sel < 0) ? ACC_W'(-acc_sel) : ACC_W'(acc_sel);
  end

  tcc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (sum),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      min_force <= '0;
      row_pos   <= '0;
      col_pos   <= '0;
      pend_v    <= 1'b0;
      out_valid <= 1'b0;
      div_start <= 1'b0;
      wait_end  <= 1'b0;
    end else begin
      if (cfg_we) begin
        min_force <= cfg_wdata;
      end
      // divider start pulses in the cycle after S_DLOAD
      div_start <= (state == S_DLOAD);
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            cur_r   <= row_pos;
            cur_c   <= col_pos;
            win_idx <= '0;
            if (col_pos == COL_W'(GRID_COLS - 1)) begin
              col_pos <= '0;
              row_pos <= (row_pos == ROW_W'(GRID_ROWS - 1)) ? '0
                                                             : row_pos + ROW_W'(1);
            end else begin
              col_pos <= col_pos + COL_W'(1);
            end
            state <= S_WIN;
          end
        end
        S_WIN: begin
          win_idx <= win_idx + 3'd1;
          if (win_idx == 3'd4) begin
            state <= S_END;
          end else if (win_ok) begin
            wi   <= win_i;
            wj   <= win_j;
            rlo  <= (win_i == '0) ? '0 : win_i - ROW_W'(1);
            rr   <= (win_i == '0) ? '0 : win_i - ROW_W'(1);
            rhi  <= (win_i == ROW_W'(GRID_ROWS - 1)) ? win_i : win_i + ROW_W'(1);
            clo  <= (win_j == '0) ? '0 : win_j - COL_W'(1);
            cc   <= (win_j == '0) ? '0 : win_j - COL_W'(1);
            chi  <= (win_j == COL_W'(GRID_COLS - 1)) ? win_j : win_j + COL_W'(1);
            for (int n = 0; n < 6; n++) acc[n] <= '0;
            sum   <= '0;
            peak  <= '0;
            k     <= '0;
            state <= S_RD;
          end
        end
        S_RD: state <= S_MAC;
        S_MAC: begin
          // product of step k is registered and added at step k+1
          if (k != 3'd6) prod <= mul_a * mul_b;
          if (k != 3'd0) acc[k - 3'd1] <= acc[k - 3'd1] + ACC_W'(prod);
          if (k == 3'd0) begin
            sum <= sum + SUM_W'(rd_q.pressure);
            if (rd_q.pressure > peak) peak <= rd_q.pressure;
            if (rr == wi && cc == wj) begin
              sz_w <= rd_q.w;
              sz_h <= rd_q.h;
            end
          end
          if (k == 3'd6) begin
            k <= '0;
            if (cc == chi) begin
              cc <= clo;
              if (rr == rhi) begin
                state <= S_F1;
              end else begin
                rr    <= rr + ROW_W'(1);
                state <= S_RD;
              end
            end else begin
              cc    <= cc + COL_W'(1);
              state <= S_RD;
            end
          end else begin
            k <= k + 3'd1;
          end
        end
        S_F1: begin
          prod  <= mul_a * mul_b;
          state <= S_F2;
        end
        S_F2: begin
          prod  <= mul_a * mul_b;
          state <= S_F3;
        end
        S_F3: begin
          force_v <= prod[FORCE_W-1:0];
          dk      <= '0;
          state   <= (prod[FORCE_W-1:0] > min_force && sum != '0) ? S_DLOAD : S_WIN;
        end
        S_DLOAD: begin
          // round half away from zero on the magnitude
          dneg      <= acc_sel < 0;
          div_num   <= NUM_W'(acc_mag) + NUM_W'(sum >> 1);
          state     <= S_DWAIT;
        end
        S_DWAIT: begin
          if (div_done) begin
            vals[dk] <= dneg ? 16'(-div_q) : 16'(div_q);
            if (dk == 3'd5) begin
              state <= S_PUSH;
            end else begin
              dk    <= dk + 3'd1;
              state <= S_DLOAD;
            end
          end
        end
        S_PUSH: begin
          pend   <= '{row: 4'(wi), col: 4'(wj), val: vals, force_v: force_v};
          pend_v <= 1'b1;
          if (pend_v) begin
            out_q     <= pend;
            out_valid <= 1'b1;
            wait_end  <= 1'b0;
            state     <= S_WAIT;
          end else begin
            state <= S_WIN;
          end
        end
        S_END: begin
          if (pend_v) begin
            out_q     <= pend;
            out_valid <= 1'b1;
            pend_v    <= 1'b0;
            wait_end  <= 1'b1;
            state     <= S_WAIT;
          end else begin
            state <= S_IDLE;
          end
        end
        S_WAIT: begin
          if (out_ch.ready) begin
            out_valid <= 1'b0;
            state     <= wait_end ? S_IDLE : S_WIN;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.contact_row = out_q.row;
  assign out_ch.contact_col = out_q.col;
  assign out_ch.point_x     = out_q.val[0];
  assign out_ch.point_y     = out_q.val[1];
  assign out_ch.point_z     = out_q.val[2];
  assign out_ch.dir_x       = out_q.val[3];
  assign out_ch.dir_y       = out_q.val[4];
  assign out_ch.dir_z       = out_q.val[5];
  assign out_ch.force_res   = out_q.force_v;
  assign out_ch.last_of_run = wait_end;

  `TCC_ASSERT_IMP(a_idle_clear, in_ch.ready, !out_valid && !pend_v)
  `TCC_ASSERT_IMP(a_div_free, div_start, !div_busy)
  `TCC_ASSERT_IMP(a_win_span, state == S_MAC, rr >= rlo && rr <= rhi && cc >= clo && cc <= chi)
  `TCC_ASSERT_NXT(a_last_drain, out_valid && wait_end && out_ch.ready, state == S_IDLE)
endmodule

// ----- verif/tb_tactile_contact_centroid_3x3.sv -----
// Testbench for the 3x3 weighted contact centroid block: random texel stream, scoreboard check.
`timescale 1ns / 1ps
module tb_tactile_contact_centroid_3x3 import tcc_pkg::*; ();

  localparam int ROWS = GRID_ROWS_DEF;
  localparam int COLS = GRID_COLS_DEF;
  localparam longint MASK48 = 64'hFFFF_FFFF_FFFF;
  // settle time meant to cover the worst texel (grid corner, four contacts)
  localparam int SETTLE_CYCLES = 1000;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic [15:0]        pressure;
    logic signed [15:0] c[3];
    logic signed [15:0] n[3];
    logic [15:0]        w;
    logic [15:0]        h;
  } texel_s;

  typedef struct {
    logic [3:0]         row;
    logic [3:0]         col;
    logic signed [15:0] pt[3];
    logic signed [15:0] dir[3];
    logic [47:0]        force_v;
    logic               last;
  } contact_s;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [FORCE_W-1:0] cfg_wdata = '0;

  tcc_in_if  in_ch();
  tcc_out_if out_ch();

  tactile_contact_centroid_3x3 uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: three-row line store plus raster position and threshold.
  // ---------------------------------------------------------------------------
  texel_s   line_store[3*COLS];
  int       cur_row = 0;
  int       cur_col = 0;
  longint   min_force_q = 0;
  contact_s contacts_due[$];
  texel_s   texels_pending[$];

  int errors = 0;
  int texels_sent = 0;
  int contacts_seen = 0;
  int cycles = 0;
  logic burst_in = 1'b0;    // no-gap stretch on the sender side
  logic burst_out = 1'b0;   // no-stall stretch on the receiver side
  logic hold_req = 1'b0;    // asks the receiver for one long hold-off
  logic hold_done = 1'b0;

  // Rounded mean: ties go away from zero, kept to 16 bits.
  function automatic logic [15:0] round_mean(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    if (num < 0) q = -q;
    return q[15:0];
  endfunction

  // Evaluate window centered on (i,j); queue a contact if the force clears the threshold and the weight sum is nonzero.
  function automatic int eval_window(int i, int j);
    int rlo, rhi, clo, chi, s;
    longint sc[3], sn[3], wsum, peak, p, frc;
    contact_s ct;
    rlo = (i == 0) ? 0 : i - 1;
    rhi = (i + 1 > ROWS - 1) ? ROWS - 1 : i + 1;
    clo = (j == 0) ? 0 : j - 1;
    chi = (j + 1 > COLS - 1) ? COLS - 1 : j + 1;
    wsum = 0;
    peak = 0;
    for (int k = 0; k < 3; k++) begin
      sc[k] = 0;
      sn[k] = 0;
    end
    for (int r = rlo; r <= rhi; r++)
      for (int c = clo; c <= chi; c++) begin
        s = (r % 3) * COLS + c;
        p = longint'(line_store[s].pressure);
        for (int k = 0; k < 3; k++) begin
          sc[k] += p * longint'(line_store[s].c[k]);
          sn[k] += p * longint'(line_store[s].n[k]);
        end
        wsum += p;
        if (p > peak) peak = p;
      end
    s = (i % 3) * COLS + j;
    frc = (peak * longint'(line_store[s].w) * longint'(line_store[s].h)) & MASK48;
    if (frc <= min_force_q || wsum == 0) return 0;
    ct.row = i[3:0];
    ct.col = j[3:0];
    for (int k = 0; k < 3; k++) begin
      ct.pt[k]  = round_mean(sc[k], wsum);
      ct.dir[k] = round_mean(sn[k], wsum);
    end
    ct.force_v = frc[47:0];
    ct.last = 1'b0;
    contacts_due = {contacts_due, ct};
    return 1;
  endfunction

  // Store one accepted texel and queue every contact it completes.
  function automatic void predict_contacts(texel_s t);
    int r, c, n;
    r = cur_row;
    c = cur_col;
    n = 0;
    line_store[(r % 3) * COLS + c] = t;
    if (r >= 1 && c >= 1) n += eval_window(r - 1, c - 1);
    if (r >= 1 && c == COLS - 1) n += eval_window(r - 1, c);
    if (r == ROWS - 1 && c >= 1) n += eval_window(r, c - 1);
    if (r == ROWS - 1 && c == COLS - 1) n += eval_window(r, c);
    if (n > 0) contacts_due[$].last = 1'b1;
    if (c + 1 >= COLS) begin
      cur_col = 0;
      cur_row = (r + 1 >= ROWS) ? 0 : r + 1;
    end else begin
      cur_col = c + 1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: pops texels, random gaps, predicts at each input transfer.
  // ---------------------------------------------------------------------------
  texel_s on_bus;
  int     gap_left = 0;

  always @(posedge clk) begin
    logic nv;
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      nv = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        predict_contacts(on_bus);
        texels_sent++;
        nv = 1'b0;
        gap_left = burst_in ? 0 : $urandom_range(0, 3);
      end
      if (!nv && texels_pending.size() > 0) begin
        if (gap_left > 0) begin
          gap_left--;
        end else begin
          on_bus = texels_pending.pop_front();
          in_ch.pressure     <= on_bus.pressure;
          in_ch.center_x     <= on_bus.c[0];
          in_ch.center_y     <= on_bus.c[1];
          in_ch.center_z     <= on_bus.c[2];
          in_ch.normal_x     <= on_bus.n[0];
          in_ch.normal_y     <= on_bus.n[1];
          in_ch.normal_z     <= on_bus.n[2];
          in_ch.texel_width  <= on_bus.w;
          in_ch.texel_height <= on_bus.h;
          nv = 1'b1;
        end
      end
      in_ch.valid <= nv;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random stalls, one long hold-off on request, field-by-field check.
  // ---------------------------------------------------------------------------
  int stall_left = 0;
  int hold_left = 0;

  task automatic report(string what, longint exp_v, longint act_v);
    errors++;
    if (errors <= 40)
      $display("%0t ERROR %s: expected %0d actual %0d", $time, what, exp_v, act_v);
  endtask

  always @(posedge clk) begin
    contact_s e;
    logic rdy;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        contacts_seen++;
        if (contacts_due.size() == 0) begin
          report("contact with none expected, row", -1, out_ch.contact_row);
        end else begin
          e = contacts_due.pop_front();
          if (out_ch.contact_row !== e.row) report("contact_row", e.row, out_ch.contact_row);
          if (out_ch.contact_col !== e.col) report("contact_col", e.col, out_ch.contact_col);
          if (out_ch.point_x !== e.pt[0]) report("point_x", e.pt[0], out_ch.point_x);
          if (out_ch.point_y !== e.pt[1]) report("point_y", e.pt[1], out_ch.point_y);
          if (out_ch.point_z !== e.pt[2]) report("point_z", e.pt[2], out_ch.point_z);
          if (out_ch.dir_x !== e.dir[0]) report("dir_x", e.dir[0], out_ch.dir_x);
          if (out_ch.dir_y !== e.dir[1]) report("dir_y", e.dir[1], out_ch.dir_y);
          if (out_ch.dir_z !== e.dir[2]) report("dir_z", e.dir[2], out_ch.dir_z);
          if (out_ch.force_res !== e.force_v) report("force_res", e.force_v, out_ch.force_res);
          if (out_ch.last_of_run !== e.last) report("last_of_run", e.last, out_ch.last_of_run);
        end
        stall_left = burst_out ? 0 : $urandom_range(0, 3);
      end
      if (hold_req && !hold_done) begin
        hold_done <= 1'b1;
        hold_left = 600;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      out_ch.ready <= rdy;
    end
  end

  // Watchdog: only counts while work is outstanding and nothing moves.
  int quiet = 0;
  always @(posedge clk) begin
    cycles++;
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        !(texels_pending.size() > 0 || in_ch.valid || contacts_due.size() > 0))
      quiet = 0;
    else
      quiet++;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("%0t timeout: %0d contacts still due", $time, contacts_due.size());
      $display("FAIL tactile_contact_centroid_3x3");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic logic [15:0] rnd_u16();
    int m;
    m = $urandom_range(0, 9);
    if (m == 0) return 16'h0000;
    if (m == 1) return 16'hFFFF;
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic signed [15:0] rnd_s16();
    int m;
    m = $urandom_range(0, 9);
    if (m == 0) return -16'sd32768;
    if (m == 1) return 16'sd32767;
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic signed [15:0] rnd_norm();
    int m;
    m = $urandom_range(0, 9);
    if (m == 0) return -16'sd16384;
    if (m == 1) return 16'sd16384;
    return 16'($urandom_range(0, 32768) - 16384);
  endfunction

  function automatic texel_s rnd_texel();
    texel_s t;
    t.pressure = ($urandom_range(0, 6) == 0) ? 16'h0 : rnd_u16();
    for (int k = 0; k < 3; k++) begin
      t.c[k] = rnd_s16();
      t.n[k] = rnd_norm();
    end
    t.w = rnd_u16();
    t.h = rnd_u16();
    return t;
  endfunction

  task automatic cfg_write(longint v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v[47:0];
    min_force_q = v & MASK48;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Sender pause: everything delivered and the block given time to finish.
  task automatic wait_drained();
    do @(posedge clk);
    while (texels_pending.size() > 0 || in_ch.valid || contacts_due.size() > 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_random(int count);
    for (int k = 0; k < count; k++) begin
      if (k % 40 == 0) begin
        burst_in = ($urandom_range(0, 3) == 0);
        burst_out = ($urandom_range(0, 3) == 0);
      end
      texels_pending = {texels_pending, rnd_texel()};
    end
  endtask

  initial begin
    texel_s t;
    longint thr;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: first 20 texels, threshold at its reset value of zero.
    // Left corner of rows 0/1 carries no pressure, so the corner windows
    // have a zero weight sum and must stay silent. Others take field extremes.
    for (int k = 0; k < 20; k++) begin
      t.pressure = (k < 3 || (k >= 16 && k < 19)) ? 16'h0 :
                   (k % 2 == 0) ? 16'hFFFF : 16'h0001;
      for (int f = 0; f < 3; f++) begin
        t.c[f] = ((k + f) % 2 == 0) ? -16'sd32768 : 16'sd32767;
        t.n[f] = ((k + f) % 3 == 0) ? -16'sd16384 : 16'sd16384;
      end
      t.w = (k % 5 == 4) ? 16'h0 : 16'hFFFF;
      t.h = (k % 7 == 6) ? 16'h0 : 16'hFFFF;
      texels_pending = {texels_pending, t};
    end
    wait_drained();

    // Zero threshold: every nonzero force is a contact.
    cfg_write(0);
    queue_random(120);
    wait_drained();

    // Full-scale threshold: nothing may come out.
    cfg_write(MASK48);
    queue_random(30);
    wait_drained();

    // Mid-range threshold, with one long receiver hold-off partway through.
    thr = {$urandom_range(0, 65535), $urandom()};
    cfg_write(thr >> 2);
    queue_random(120);
    repeat (200) @(posedge clk);
    hold_req = 1'b1;
    wait_drained();

    // Threshold of one: a force of exactly one is rejected.
    cfg_write(1);
    queue_random(80);
    wait_drained();

    $display("Sent %0d texels (grid corner and frame wrap included) over five thresholds,",
             texels_sent);
    $display("checked %0d contacts in %0d cycles with random gaps and stalls.",
             contacts_seen, cycles);
    if (errors == 0) begin
      $display("PASS tactile_contact_centroid_3x3");
    end else begin
      $display("FAIL tactile_contact_centroid_3x3");
    end
    $finish;
  end

endmodule
